>>> rtl/ow_pkg.sv
// shared types, codes and timing constants of the one-wire bus master
package ow_pkg;

  localparam int unsigned TickW = 11;

  // presence window length and reset retries
  localparam logic [4:0] PRESENCE_SAMPLES = 5'd30;
  localparam logic [1:0] RESET_ATTEMPTS   = 2'd3;

  // reset timing in ticks
  localparam logic [TickW-1:0] RST_LOW_STD  = 11'd500;
  localparam logic [TickW-1:0] RST_LOW_OD   = 11'd50;
  localparam logic [TickW-1:0] RST_WAIT_STD = 11'd60;
  localparam logic [TickW-1:0] RST_WAIT_OD  = 11'd1;
  localparam logic [TickW-1:0] RST_REC_STD  = 11'd1000;
  localparam logic [TickW-1:0] RST_REC_OD   = 11'd40;

  // bit slot timing in ticks, before scaling; SLOT1_LOW is used unscaled
  localparam logic [TickW-1:0] SLOT0_LOW_STD = 11'd60;
  localparam logic [TickW-1:0] SLOT0_LOW_OD  = 11'd8;
  localparam logic [TickW-1:0] SLOT0_REL_STD = 11'd10;
  localparam logic [TickW-1:0] SLOT0_REL_OD  = 11'd5;
  localparam logic [TickW-1:0] SLOT1_REL_STD = 11'd55;
  localparam logic [TickW-1:0] SLOT1_REL_OD  = 11'd8;
  localparam logic [TickW-1:0] SLOT1_LOW     = 11'd1;

  // configuration register indexes
  localparam logic [1:0] CFG_OVERDRIVE  = 2'd0;
  localparam logic [1:0] CFG_OPEN_DRAIN = 2'd1;
  localparam logic [1:0] CFG_SCALE      = 2'd2;

  typedef enum logic [2:0] {
    ACT_RESET   = 3'd0,
    ACT_TOUCH   = 3'd1,
    ACT_TRIPLET = 3'd2,
    ACT_WRITE   = 3'd3,
    ACT_READ    = 3'd4
  } action_e;

  typedef enum logic [7:0] {
    PH_IDLE  = 8'b0000_0001,
    PH_RLOW  = 8'b0000_0010,
    PH_RWAIT = 8'b0000_0100,
    PH_RSAMP = 8'b0000_1000,
    PH_RREC  = 8'b0001_0000,
    PH_SLOW  = 8'b0010_0000,
    PH_SSAMP = 8'b0100_0000,
    PH_SREL  = 8'b1000_0000
  } phase_e;

  typedef struct packed {
    logic       overdrive_speed;
    logic       open_drain_mode;
    logic [3:0] delay_scale;
  } cfg_t;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] action;
    logic [7:0] cmd_data;
    logic       line_level;
  } cmd_t;

  typedef struct packed {
    logic       pin_drive_enable;
    logic       pin_drive_value;
    logic       busy_res;
    logic       done_res;
    logic [7:0] result_value;
  } res_t;

  // a scale of zero acts as one
  function automatic logic [TickW-1:0] eff_scale(input logic [3:0] ds);
    return (ds == 4'd0) ? 11'd1 : {7'd0, ds};
  endfunction

  // bit that the current slot puts on the bus
  function automatic logic slot_bit(input action_e cc, input logic [2:0] bi,
                                    input logic [2:0] sr, input logic [7:0] sb);
    if (cc == ACT_TRIPLET) begin
      return (bi < 3'd2) ? 1'b1 : sr[2];
    end
    return sb[0];
  endfunction

endpackage

>>> rtl/ow_if.sv
// item channels of the one-wire bus master: command ticks in, results out
interface ow_cmd_if;
  logic       valid;
  logic       ready;
  logic       cmd_valid;
  logic [2:0] action;
  logic [7:0] cmd_data;
  logic       line_level;

  modport source (output valid, cmd_valid, action, cmd_data, line_level, input ready);
  modport sink   (input valid, cmd_valid, action, cmd_data, line_level, output ready);
endinterface

interface ow_res_if;
  logic       valid;
  logic       ready;
  logic       pin_drive_enable;
  logic       pin_drive_value;
  logic       busy_res;
  logic       done_res;
  logic [7:0] result_value;

  modport source (output valid, pin_drive_enable, pin_drive_value, busy_res, done_res,
                  result_value, input ready);
  modport sink   (input valid, pin_drive_enable, pin_drive_value, busy_res, done_res,
                  result_value, output ready);
endinterface

>>> rtl/ow_core.sv
// sequence state and single-tick update logic of the one-wire bus master
module ow_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  ow_pkg::cmd_t  cmd_i,
  input  ow_pkg::cfg_t  cfg_i,
  output ow_pkg::res_t  res_o
);

  ow_pkg::phase_e                 phase_q, phase_d;
  ow_pkg::action_e                cmd_q, cmd_d;
  logic [ow_pkg::TickW-1:0]       tick_q, tick_d;
  logic [2:0]                     bit_q, bit_d;
  logic [7:0]                     shift_q, shift_d;
  logic [1:0]                     att_q, att_d;
  logic [4:0]                     samp_q, samp_d;
  logic                           pres_q, pres_d;
  logic [2:0]                     srch_q, srch_d;

  logic                           drive_low, done, expired, sb_bit, sb_smp, fin;
  logic [7:0]                     res_val;
  logic [ow_pkg::TickW-1:0]       scl, rel;

  assign scl = ow_pkg::eff_scale(cfg_i.delay_scale);

  always_comb begin
    phase_d   = phase_q;
    cmd_d     = cmd_q;
    tick_d    = tick_q;
    bit_d     = bit_q;
    shift_d   = shift_q;
    att_d     = att_q;
    samp_d    = samp_q;
    pres_d    = pres_q;
    srch_d    = srch_q;
    drive_low = 1'b0;
    done      = 1'b0;
    res_val   = 8'd0;
    expired   = 1'b0;
    sb_bit    = 1'b0;
    sb_smp    = 1'b0;
    rel       = '0;
    fin       = 1'b0;

    // a command on an idle tick starts its sequence on this same tick
    if (phase_q == ow_pkg::PH_IDLE && cmd_i.cmd_valid && cmd_i.action <= ow_pkg::ACT_READ) begin
      cmd_d  = ow_pkg::action_e'(cmd_i.action);
      bit_d  = 3'd0;
      srch_d = 3'd0;
      if (cmd_d == ow_pkg::ACT_RESET) begin
        att_d   = ow_pkg::RESET_ATTEMPTS;
        phase_d = ow_pkg::PH_RLOW;
        tick_d  = cfg_i.overdrive_speed ? ow_pkg::RST_LOW_OD : ow_pkg::RST_LOW_STD;
        pres_d  = 1'b1;
        samp_d  = 5'd0;
      end else begin
        if (cmd_d == ow_pkg::ACT_WRITE) begin
          shift_d = cmd_i.cmd_data;
        end else if (cmd_d == ow_pkg::ACT_READ) begin
          shift_d = 8'hFF;
        end else begin
          shift_d = {7'd0, cmd_i.cmd_data[0]};
        end
        phase_d = ow_pkg::PH_SLOW;
        tick_d  = ow_pkg::slot_bit(cmd_d, bit_d, srch_d, shift_d) ? ow_pkg::SLOT1_LOW :
                  scl * (cfg_i.overdrive_speed ? ow_pkg::SLOT0_LOW_OD : ow_pkg::SLOT0_LOW_STD);
      end
    end

    unique case (phase_d)
      ow_pkg::PH_IDLE: begin
      end
      ow_pkg::PH_RLOW: begin
        drive_low = 1'b1;
        expired   = (tick_d <= 11'd1);
        tick_d    = expired ? '0 : tick_d - 11'd1;
        if (expired) begin
          phase_d = ow_pkg::PH_RWAIT;
          tick_d  = cfg_i.overdrive_speed ? ow_pkg::RST_WAIT_OD : ow_pkg::RST_WAIT_STD;
        end
      end
      ow_pkg::PH_RWAIT: begin
        expired = (tick_d <= 11'd1);
        tick_d  = expired ? '0 : tick_d - 11'd1;
        if (expired) begin
          phase_d = ow_pkg::PH_RSAMP;
          samp_d  = 5'd0;
        end
      end
      ow_pkg::PH_RSAMP: begin
        pres_d = pres_d & cmd_i.line_level;
        samp_d = samp_d + 5'd1;
        if (samp_d >= ow_pkg::PRESENCE_SAMPLES || samp_d == 5'd0) begin
          phase_d = ow_pkg::PH_RREC;
          tick_d  = cfg_i.overdrive_speed ? ow_pkg::RST_REC_OD : ow_pkg::RST_REC_STD;
        end
      end
      ow_pkg::PH_RREC: begin
        expired = (tick_d <= 11'd1);
        tick_d  = expired ? '0 : tick_d - 11'd1;
        if (expired) begin
          if (!pres_d) begin
            done    = 1'b1;
            res_val = 8'd0;
          end else if (att_d <= 2'd1) begin
            att_d   = 2'd0;
            done    = 1'b1;
            res_val = 8'd1;
          end else begin
            // no answer yet: start another attempt
            att_d   = att_d - 2'd1;
            phase_d = ow_pkg::PH_RLOW;
            tick_d  = cfg_i.overdrive_speed ? ow_pkg::RST_LOW_OD : ow_pkg::RST_LOW_STD;
            pres_d  = 1'b1;
            samp_d  = 5'd0;
          end
        end
      end
      ow_pkg::PH_SLOW: begin
        drive_low = 1'b1;
        expired   = (tick_d <= 11'd1);
        tick_d    = expired ? '0 : tick_d - 11'd1;
        if (expired) begin
          phase_d = ow_pkg::PH_SSAMP;
        end
      end
      ow_pkg::PH_SSAMP: begin
        sb_bit = ow_pkg::slot_bit(cmd_d, bit_d, srch_d, shift_d);
        sb_smp = sb_bit & cmd_i.line_level;
        if (sb_bit) begin
          rel = scl * (cfg_i.overdrive_speed ? ow_pkg::SLOT1_REL_OD : ow_pkg::SLOT1_REL_STD);
        end else begin
          rel = scl * (cfg_i.overdrive_speed ? ow_pkg::SLOT0_REL_OD : ow_pkg::SLOT0_REL_STD);
        end
        if (cmd_d == ow_pkg::ACT_TOUCH) begin
          shift_d = {7'd0, sb_smp};
        end else if (cmd_d == ow_pkg::ACT_TRIPLET) begin
          if (bit_d == 3'd0) begin
            srch_d = {2'd0, sb_smp};
            bit_d  = 3'd1;
          end else if (bit_d == 3'd1) begin
            srch_d = srch_d | {1'b0, sb_smp, 1'b0};
            if (srch_d == 3'd3) begin
              // neither id nor complement pulled low: no device
              bit_d = 3'd3;
            end else begin
              if (srch_d == 3'd0) begin
                srch_d = shift_d[0] ? 3'd4 : 3'd0;
              end else begin
                srch_d = srch_d[0] ? 3'd5 : 3'd2;
              end
              bit_d = 3'd2;
            end
          end else begin
            bit_d = 3'd3;
          end
        end else begin
          shift_d = {sb_smp, shift_d[7:1]};
          bit_d   = bit_d + 3'd1;
        end
        phase_d = ow_pkg::PH_SREL;
        tick_d  = rel - 11'd1;
      end
      ow_pkg::PH_SREL: begin
        expired = (tick_d <= 11'd1);
        tick_d  = expired ? '0 : tick_d - 11'd1;
        if (expired) begin
          if (cmd_d == ow_pkg::ACT_TOUCH) begin
            fin = 1'b1;
          end else if (cmd_d == ow_pkg::ACT_TRIPLET) begin
            fin = (bit_d == 3'd3);
          end else begin
            fin = (bit_d == 3'd0);
          end
          if (fin) begin
            done = 1'b1;
            if (cmd_d == ow_pkg::ACT_TOUCH) begin
              res_val = {7'd0, shift_d[0]};
            end else if (cmd_d == ow_pkg::ACT_TRIPLET) begin
              res_val = {5'd0, srch_d};
            end else if (cmd_d == ow_pkg::ACT_READ) begin
              res_val = shift_d;
            end else begin
              res_val = 8'd0;
            end
          end else begin
            phase_d = ow_pkg::PH_SLOW;
            tick_d  = ow_pkg::slot_bit(cmd_d, bit_d, srch_d, shift_d) ? ow_pkg::SLOT1_LOW :
                      scl * (cfg_i.overdrive_speed ? ow_pkg::SLOT0_LOW_OD :
                                                     ow_pkg::SLOT0_LOW_STD);
          end
        end
      end
      default: begin
        phase_d = ow_pkg::PH_IDLE;
      end
    endcase

    if (done) begin
      phase_d = ow_pkg::PH_IDLE;
    end
  end

  always_comb begin
    res_o.pin_drive_enable = drive_low | cfg_i.open_drain_mode;
    res_o.pin_drive_value  = ~drive_low & cfg_i.open_drain_mode;
    res_o.busy_res         = (phase_d != ow_pkg::PH_IDLE);
    res_o.done_res         = done;
    res_o.result_value     = res_val;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ow_pkg::PH_IDLE;
      cmd_q   <= ow_pkg::ACT_RESET;
      tick_q  <= '0;
      bit_q   <= 3'd0;
      shift_q <= 8'd0;
      att_q   <= 2'd0;
      samp_q  <= 5'd0;
      pres_q  <= 1'b1;
      srch_q  <= 3'd0;
    end else if (step_i) begin
      phase_q <= phase_d;
      cmd_q   <= cmd_d;
      tick_q  <= tick_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      att_q   <= att_d;
      samp_q  <= samp_d;
      pres_q  <= pres_d;
      srch_q  <= srch_d;
    end
  end

endmodule

>>> rtl/onewire_bus_master_top.sv
// top level of the one-wire bus master: config registers, handshake, result register
//
// Each input item is one microsecond tick: the sampled line level plus an
// optional command (bus reset with presence detect, touch bit, search
// triplet, write byte, read byte). Every accepted item produces exactly one
// result item carrying the pin drive for that tick, busy, done and the
// command result. The block takes one item per clock cycle: the whole tick
// update runs in one pass from the sequence state registers to the result
// register, so throughput is bounded only by the result register, which
// accepts a new item whenever it is empty or being taken in the same cycle.
// An accepted item's result is registered and appears in the next cycle.
// Configuration (overdrive timing, open-drain mode, delay scale) is written
// through a simple write port and should be changed only while no command runs.
module onewire_bus_master_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  ow_cmd_if.sink     cmd_ch,
  ow_res_if.source   res_ch,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [3:0] cfg_wdata_i
);

  ow_pkg::cfg_t cfg_q;
  ow_pkg::cmd_t cmd;
  ow_pkg::res_t res_d, res_q;
  logic         out_valid_q;
  logic         step;

  // config registers, index beyond the list is dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.overdrive_speed <= 1'b0;
      cfg_q.open_drain_mode <= 1'b0;
      cfg_q.delay_scale     <= 4'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ow_pkg::CFG_OVERDRIVE:  cfg_q.overdrive_speed <= cfg_wdata_i[0];
        ow_pkg::CFG_OPEN_DRAIN: cfg_q.open_drain_mode <= cfg_wdata_i[0];
        ow_pkg::CFG_SCALE:      cfg_q.delay_scale     <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // take a tick whenever the result register is free or draining
  assign cmd_ch.ready = ~out_valid_q | res_ch.ready;
  assign step         = cmd_ch.valid & cmd_ch.ready;

  assign cmd.cmd_valid  = cmd_ch.cmd_valid;
  assign cmd.action     = cmd_ch.action;
  assign cmd.cmd_data   = cmd_ch.cmd_data;
  assign cmd.line_level = cmd_ch.line_level;

  ow_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .cmd_i  (cmd),
    .cfg_i  (cfg_q),
    .res_o  (res_d)
  );

  // result register, payload needs no reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (res_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign res_ch.valid            = out_valid_q;
  assign res_ch.pin_drive_enable = res_q.pin_drive_enable;
  assign res_ch.pin_drive_value  = res_q.pin_drive_value;
  assign res_ch.busy_res         = res_q.busy_res;
  assign res_ch.done_res         = res_q.done_res;
  assign res_ch.result_value     = res_q.result_value;

endmodule

>>> rtl/ow_checker.sv
// port-level assertions of the one-wire bus master and their bind
module ow_checker (
  input logic      clk_i,
  input logic      rst_ni,
  ow_cmd_if.sink   cmd_ch,
  ow_res_if.source res_ch
);

  // a completing item never reports busy
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_ch.valid && res_ch.done_res |-> !res_ch.busy_res)
    else $error("done reported together with busy");

  // result field is clear unless a command completes
  a_result_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_ch.valid && !res_ch.done_res |-> res_ch.result_value == 8'd0)
    else $error("result value set without done");

  // a released pin carries no drive level
  a_release_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_ch.valid && !res_ch.pin_drive_enable |-> !res_ch.pin_drive_value)
    else $error("drive value set while pin released");

  // input taken exactly when the result register can move
  a_ready_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_ch.ready == (!res_ch.valid || res_ch.ready))
    else $error("input ready does not follow result register state");

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_ch.valid && !res_ch.ready |=> res_ch.valid && $stable(res_ch.result_value)
      && $stable(res_ch.done_res) && $stable(res_ch.busy_res))
    else $error("stalled result item changed");

endmodule

bind onewire_bus_master_top ow_checker u_ow_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .cmd_ch (cmd_ch),
  .res_ch (res_ch)
);
